FILE: rtl/core/mpeg_pkg.sv
// ----------------------------------------------------------------------------
// mpeg_pkg
// Shared constants, register indexes, state codes and unit command types for
// the multi-point envelope generator.
// ----------------------------------------------------------------------------
package mpeg_pkg;

   localparam int MAX_POINTS  = 4;
   localparam int FRAME_RATE  = 48000;
   localparam int POINT_REGS  = 4;
   localparam int PT_ADDR_W   = 2;

   localparam int SAMPLE_W    = 16;
   localparam int LEVEL_W     = 16;
   localparam int AMP_W       = 16;
   localparam int DUR_W       = 16;
   localparam int POINT_W     = 33;
   localparam int ELAPSED_W   = 32;
   localparam int COUNT_W     = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 33;

   localparam int TOTAL_LIMIT = (MAX_POINTS < POINT_REGS) ? MAX_POINTS : POINT_REGS;

   localparam int PROG_W      = 17;
   localparam logic [PROG_W-1:0]    ONE_Q16   = PROG_W'(65536);
   localparam logic [LEVEL_W-1:0]   UNITY_Q14 = LEVEL_W'(16384);
   localparam logic [ELAPSED_W-1:0] MS_STEP   =
      ELAPSED_W'((65536000 + FRAME_RATE / 2) / FRAME_RATE);
   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX   = {ELAPSED_W{1'b1}};
   localparam logic [ELAPSED_W-1:0] ELAPSED_LIMIT = ELAPSED_MAX - MS_STEP;

   // bit-serial multiplier: signed multiplicand, unsigned multiplier
   localparam int MUL_A_W     = 18;
   localparam int MUL_B_W     = 17;
   localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
   localparam int MUL_STEPS   = MUL_B_W;
   localparam int MUL_CNT_W   = $clog2(MUL_STEPS + 1);

   // restoring divider, one quotient bit per cycle
   localparam int DIV_Q_W     = 16;
   localparam int DIV_STEPS   = DIV_Q_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_POINT_0    = 3'd0,
      CSR_POINT_1    = 3'd1,
      CSR_POINT_2    = 3'd2,
      CSR_POINT_3    = 3'd3,
      CSR_NUM_POINTS = 3'd4,
      CSR_LOOP_START = 3'd5,
      CSR_LOOP_END   = 3'd6,
      CSR_RELEASE_MS = 3'd7
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PLAN,
      S_FROM,
      S_RATE,
      S_DIV_GO,
      S_DIV_WAIT,
      S_SQ_GO,
      S_SQ_WAIT,
      S_MIX_GO,
      S_MIX_WAIT,
      S_SCALE_GO,
      S_SCALE_WAIT,
      S_DONE
   } env_state_type;

   typedef struct packed {
      logic                 start;
      logic [MUL_A_W-1:0]   mcand;
      logic [MUL_B_W-1:0]   mplier;
   } mul_cmd_type;

   typedef struct packed {
      logic                 start;
      logic [ELAPSED_W-1:0] dividend;
      logic [DUR_W-1:0]     divisor;
   } div_cmd_type;

endpackage

FILE: rtl/core/mpeg_if.sv
// ----------------------------------------------------------------------------
// mpeg_if
// Valid/ready channels for sample requests and scaled sample responses.
// ----------------------------------------------------------------------------
interface mpeg_req_if;
   import mpeg_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] left_in;
   logic signed [SAMPLE_W-1:0] right_in;
   logic                       key_off;

   modport source (output valid, output left_in, output right_in, output key_off,
                   input ready);
   modport sink (input valid, input left_in, input right_in, input key_off,
                 output ready);
endinterface

interface mpeg_rsp_if;
   import mpeg_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] left_out;
   logic signed [SAMPLE_W-1:0] right_out;
   logic [LEVEL_W-1:0]         level;

   modport source (output valid, output left_out, output right_out, output level,
                   input ready);
   modport sink (input valid, input left_out, input right_out, input level,
                 output ready);
endinterface

FILE: rtl/core/mpeg_sdiv.sv
// ----------------------------------------------------------------------------
// mpeg_sdiv
// Restoring divider, one quotient bit per cycle. Expects the upper half of
// the dividend to be below the divisor, so the quotient fits in 16 bits.
// ----------------------------------------------------------------------------
module mpeg_sdiv (
   input  logic                           clock,
   input  logic                           reset,
   input  mpeg_pkg::div_cmd_type          cmd,
   output logic                           done,
   output logic [mpeg_pkg::DIV_Q_W-1:0]   quotient
);
   import mpeg_pkg::*;

   logic [DUR_W-1:0]     rem_ff,  rem_in;
   logic [DIV_Q_W-1:0]   low_ff,  low_in;
   logic [DUR_W-1:0]     dsr_ff,  dsr_in;
   logic [DIV_CNT_W-1:0] cnt_ff,  cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DUR_W:0]       trial;
   logic                 fits;

   always_comb begin
      trial   = {rem_ff, low_ff[DIV_Q_W-1]};
      fits    = trial >= {1'b0, dsr_ff};
      rem_in  = rem_ff;
      low_in  = low_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         rem_in  = cmd.dividend[ELAPSED_W-1:DIV_Q_W];
         low_in  = cmd.dividend[DIV_Q_W-1:0];
         dsr_in  = cmd.divisor;
         cnt_in  = DIV_CNT_W'(DIV_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? DUR_W'(trial - {1'b0, dsr_ff}) : trial[DUR_W-1:0];
         low_in  = {low_ff[DIV_Q_W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         busy_in = cnt_ff != DIV_CNT_W'(1);
         done_in = cnt_ff == DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      low_ff <= low_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = low_ff;

endmodule

FILE: rtl/core/mpeg_smul.sv
// ----------------------------------------------------------------------------
// mpeg_smul
// Shift-and-add multiplier: signed multiplicand times unsigned multiplier,
// one multiplier bit per cycle, least significant bit first.
// ----------------------------------------------------------------------------
module mpeg_smul (
   input  logic                           clock,
   input  logic                           reset,
   input  mpeg_pkg::mul_cmd_type          cmd,
   output logic                           done,
   output logic [mpeg_pkg::MUL_P_W-1:0]   product
);
   import mpeg_pkg::*;

   logic [MUL_P_W-1:0]   mcand_ff,  mcand_in;
   logic [MUL_B_W-1:0]   mplier_ff, mplier_in;
   logic [MUL_P_W-1:0]   acc_ff,    acc_in;
   logic [MUL_CNT_W-1:0] cnt_ff,    cnt_in;
   logic                 busy_ff,   busy_in;
   logic                 done_ff,   done_in;

   always_comb begin
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (cmd.start) begin
         mcand_in  = {{(MUL_P_W-MUL_A_W){cmd.mcand[MUL_A_W-1]}}, cmd.mcand};
         mplier_in = cmd.mplier;
         acc_in    = '0;
         cnt_in    = MUL_CNT_W'(MUL_STEPS);
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         acc_in    = mplier_ff[0] ? acc_ff + mcand_ff : acc_ff;
         mcand_in  = {mcand_ff[MUL_P_W-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[MUL_B_W-1:1]};
         cnt_in    = cnt_ff - 1'b1;
         busy_in   = cnt_ff != MUL_CNT_W'(1);
         done_in   = cnt_ff == MUL_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

FILE: rtl/core/multi_point_envelope_generator.sv
// ----------------------------------------------------------------------------
// multi_point_envelope_generator
// Scales a stereo sample pair by a multi-point envelope with loop, key-off
// release and saturation.
// ----------------------------------------------------------------------------
// One item is in work at a time. The work is done by the bit-serial
// units: a divider for segment progress and a two-lane shift-add
// multiplier, used once for the curve, once for the blend of the two
// point amplitudes and once for scaling both samples. A finished result
// waits in the output register while the next request is taken.
module multi_point_envelope_generator (
   input  logic                                clock,
   input  logic                                reset,
   mpeg_req_if.sink                            req_ch,
   mpeg_rsp_if.source                          rsp_ch,
   input  logic                                csr_we,
   input  logic [mpeg_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mpeg_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import mpeg_pkg::*;

   // configuration
   logic [POINT_W-1:0]   point_ff [POINT_REGS];
   logic [POINT_W-1:0]   point_in [POINT_REGS];
   logic [COUNT_W-1:0]   num_points_ff, num_points_in;
   logic [COUNT_W-1:0]   loop_start_ff, loop_start_in;
   logic [COUNT_W-1:0]   loop_end_ff,   loop_end_in;
   logic [DUR_W-1:0]     release_ms_ff, release_ms_in;

   // envelope state
   env_state_type        state_ff,      state_in;
   logic [COUNT_W-1:0]   seg_idx_ff,    seg_idx_in;
   logic                 releasing_ff,  releasing_in;
   logic [ELAPSED_W-1:0] elapsed_ff,    elapsed_in;
   logic [LEVEL_W-1:0]   cur_level_ff,  cur_level_in;
   logic [LEVEL_W-1:0]   rel_level_ff,  rel_level_in;
   logic                 rsp_valid_ff,  rsp_valid_in;

   // per-item working registers
   logic [SAMPLE_W-1:0]  left_ff,       left_in;
   logic [SAMPLE_W-1:0]  right_ff,      right_in;
   logic [COUNT_W-1:0]   total_ff,      total_in;
   logic [AMP_W-1:0]     to_ff,         to_in;
   logic [AMP_W-1:0]     from_ff,       from_in;
   logic [DUR_W-1:0]     dur_ff,        dur_in;
   logic                 curved_ff,     curved_in;
   logic                 adv_ff,        adv_in;
   logic                 end_ff,        end_in;
   logic                 pass_ff,       pass_in;
   logic [PROG_W-1:0]    t_ff,          t_in;
   logic [LEVEL_W-1:0]   lvl_ff,        lvl_in;
   logic [SAMPLE_W-1:0]  res_left_ff,   res_left_in;
   logic [SAMPLE_W-1:0]  res_right_ff,  res_right_in;
   logic [SAMPLE_W-1:0]  rsp_left_ff,   rsp_left_in;
   logic [SAMPLE_W-1:0]  rsp_right_ff,  rsp_right_in;
   logic [LEVEL_W-1:0]   rsp_level_ff,  rsp_level_in;

   logic [PT_ADDR_W-1:0] rd_addr;
   logic [POINT_W-1:0]   pt;
   logic [AMP_W-1:0]     pt_amp;
   logic [DUR_W-1:0]     pt_dur;
   logic                 pt_curved;

   logic                 accept;
   logic [COUNT_W-1:0]   total_new;
   logic [ELAPSED_W-1:0] elapsed_base;
   logic [MUL_P_W-1:0]   mix_sum;

   mul_cmd_type          mul0_cmd, mul1_cmd;
   logic                 mul0_done, mul1_done;
   logic [MUL_P_W-1:0]   mul0_prod, mul1_prod;
   div_cmd_type          div_cmd;
   logic                 div_done;
   logic [DIV_Q_W-1:0]   div_quot;

   function automatic logic [SAMPLE_W-1:0] round_sat(input logic [MUL_P_W-1:0] prod);
      logic signed [MUL_P_W-1:0]    rnd;
      logic signed [MUL_P_W-15:0]   shr;
      logic [SAMPLE_W-1:0]          res;
      rnd = $signed(prod) + MUL_P_W'(8192);
      shr = rnd[MUL_P_W-1:14];
      if (shr > $signed((MUL_P_W-14)'(32767))) begin
         res = 16'h7fff;
      end else if (shr < -$signed((MUL_P_W-14)'(32768))) begin
         res = 16'h8000;
      end else begin
         res = shr[SAMPLE_W-1:0];
      end
      return res;
   endfunction

   mpeg_smul u_mul0 (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mul0_cmd),
      .done    (mul0_done),
      .product (mul0_prod)
   );

   mpeg_smul u_mul1 (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mul1_cmd),
      .done    (mul1_done),
      .product (mul1_prod)
   );

   mpeg_sdiv u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .done     (div_done),
      .quotient (div_quot)
   );

   // point read port
   always_comb begin
      case (state_ff)
         S_FROM:  rd_addr = PT_ADDR_W'(seg_idx_ff - 1'b1);
         S_PLAN:  rd_addr = (seg_idx_ff >= total_ff) ? PT_ADDR_W'(total_ff - 1'b1)
                                                     : seg_idx_ff[PT_ADDR_W-1:0];
         default: rd_addr = seg_idx_ff[PT_ADDR_W-1:0];
      endcase
   end

   assign pt        = point_ff[rd_addr];
   assign pt_amp    = pt[AMP_W-1:0];
   assign pt_dur    = pt[AMP_W+DUR_W-1:AMP_W];
   assign pt_curved = pt[POINT_W-1];

   assign accept       = req_ch.valid && req_ch.ready;
   assign req_ch.ready = state_ff == S_IDLE;
   assign total_new    = (num_points_ff > COUNT_W'(TOTAL_LIMIT)) ? COUNT_W'(TOTAL_LIMIT)
                                                               : num_points_ff;
   assign elapsed_base = (adv_ff && end_ff) ? '0 : elapsed_ff;
   assign mix_sum      = mul0_prod + mul1_prod;

   // configuration writes
   always_comb begin
      for (int i = 0; i < POINT_REGS; i++) begin
         point_in[i] = point_ff[i];
      end
      num_points_in = num_points_ff;
      loop_start_in = loop_start_ff;
      loop_end_in   = loop_end_ff;
      release_ms_in = release_ms_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_POINT_0:    point_in[0]   = csr_wdata[POINT_W-1:0];
            CSR_POINT_1:    point_in[1]   = csr_wdata[POINT_W-1:0];
            CSR_POINT_2:    point_in[2]   = csr_wdata[POINT_W-1:0];
            CSR_POINT_3:    point_in[3]   = csr_wdata[POINT_W-1:0];
            CSR_NUM_POINTS: num_points_in = csr_wdata[COUNT_W-1:0];
            CSR_LOOP_START: loop_start_in = csr_wdata[COUNT_W-1:0];
            CSR_LOOP_END:   loop_end_in   = csr_wdata[COUNT_W-1:0];
            CSR_RELEASE_MS: release_ms_in = csr_wdata[DUR_W-1:0];
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      seg_idx_in   = seg_idx_ff;
      releasing_in = releasing_ff;
      elapsed_in   = elapsed_ff;
      cur_level_in = cur_level_ff;
      rel_level_in = rel_level_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      left_in      = left_ff;
      right_in     = right_ff;
      total_in     = total_ff;
      to_in        = to_ff;
      from_in      = from_ff;
      dur_in       = dur_ff;
      curved_in    = curved_ff;
      adv_in       = adv_ff;
      end_in       = end_ff;
      pass_in      = pass_ff;
      t_in         = t_ff;
      lvl_in       = lvl_ff;
      res_left_in  = res_left_ff;
      res_right_in = res_right_ff;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      rsp_level_in = rsp_level_ff;
      mul0_cmd     = '0;
      mul1_cmd     = '0;
      div_cmd      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               left_in  = req_ch.left_in;
               right_in = req_ch.right_in;
               total_in = total_new;
               if (total_new == '0) begin
                  // no points: samples go straight through at unity
                  res_left_in  = req_ch.left_in;
                  res_right_in = req_ch.right_in;
                  lvl_in       = UNITY_Q14;
                  pass_in      = 1'b1;
                  state_in     = S_DONE;
               end else begin
                  pass_in  = 1'b0;
                  state_in = S_PLAN;
                  if (!releasing_ff && req_ch.key_off) begin
                     releasing_in = 1'b1;
                     rel_level_in = cur_level_ff;
                     elapsed_in   = '0;
                  end
               end
            end
         end

         S_PLAN: begin
            adv_in = 1'b0;
            if (releasing_ff) begin
               // release: blend from the release level down to zero
               to_in     = '0;
               from_in   = rel_level_ff;
               dur_in    = release_ms_ff;
               curved_in = 1'b0;
               state_in  = S_RATE;
            end else if (seg_idx_ff >= total_ff) begin
               lvl_in   = pt_amp;
               state_in = S_SCALE_GO;
            end else begin
               to_in     = pt_amp;
               dur_in    = pt_dur;
               curved_in = pt_curved;
               adv_in    = 1'b1;
               state_in  = S_FROM;
            end
         end

         S_FROM: begin
            from_in  = (seg_idx_ff == '0) ? '0 : pt_amp;
            state_in = S_RATE;
         end

         S_RATE: begin
            end_in = elapsed_ff[ELAPSED_W-1:DIV_Q_W] >= dur_ff;
            if (dur_ff == '0) begin
               lvl_in   = to_ff;
               state_in = S_SCALE_GO;
            end else if (elapsed_ff[ELAPSED_W-1:DIV_Q_W] >= dur_ff) begin
               t_in     = ONE_Q16;
               state_in = curved_ff ? S_SQ_GO : S_MIX_GO;
            end else begin
               state_in = S_DIV_GO;
            end
         end

         S_DIV_GO: begin
            div_cmd.start    = 1'b1;
            div_cmd.dividend = elapsed_ff;
            div_cmd.divisor  = dur_ff;
            state_in         = S_DIV_WAIT;
         end

         S_DIV_WAIT: begin
            if (div_done) begin
               t_in     = {1'b0, div_quot};
               state_in = curved_ff ? S_SQ_GO : S_MIX_GO;
            end
         end

         S_SQ_GO: begin
            mul0_cmd.start  = 1'b1;
            mul0_cmd.mcand  = {1'b0, t_ff};
            mul0_cmd.mplier = t_ff;
            state_in        = S_SQ_WAIT;
         end

         S_SQ_WAIT: begin
            if (mul0_done) begin
               t_in     = mul0_prod[PROG_W+15:16];
               state_in = S_MIX_GO;
            end
         end

         S_MIX_GO: begin
            mul0_cmd.start  = 1'b1;
            mul0_cmd.mcand  = {2'b00, to_ff};
            mul0_cmd.mplier = t_ff;
            mul1_cmd.start  = 1'b1;
            mul1_cmd.mcand  = {2'b00, from_ff};
            mul1_cmd.mplier = ONE_Q16 - t_ff;
            state_in        = S_MIX_WAIT;
         end

         S_MIX_WAIT: begin
            if (mul0_done && mul1_done) begin
               lvl_in   = mix_sum[LEVEL_W+15:16];
               state_in = S_SCALE_GO;
            end
         end

         S_SCALE_GO: begin
            mul0_cmd.start  = 1'b1;
            mul0_cmd.mcand  = {{(MUL_A_W-SAMPLE_W){left_ff[SAMPLE_W-1]}}, left_ff};
            mul0_cmd.mplier = {1'b0, lvl_ff};
            mul1_cmd.start  = 1'b1;
            mul1_cmd.mcand  = {{(MUL_A_W-SAMPLE_W){right_ff[SAMPLE_W-1]}}, right_ff};
            mul1_cmd.mplier = {1'b0, lvl_ff};
            state_in        = S_SCALE_WAIT;
         end

         S_SCALE_WAIT: begin
            if (mul0_done && mul1_done) begin
               res_left_in  = round_sat(mul0_prod);
               res_right_in = round_sat(mul1_prod);
               state_in     = S_DONE;
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_left_in  = res_left_ff;
               rsp_right_in = res_right_ff;
               rsp_level_in = lvl_ff;
               state_in     = S_IDLE;
               if (!pass_ff) begin
                  cur_level_in = lvl_ff;
                  if (adv_ff && end_ff) begin
                     if (!loop_end_ff[COUNT_W-1] && seg_idx_ff == loop_end_ff
                         && loop_start_ff < total_ff) begin
                        seg_idx_in = loop_start_ff;
                     end else begin
                        seg_idx_in = seg_idx_ff + 1'b1;
                     end
                  end
                  elapsed_in = (elapsed_base > ELAPSED_LIMIT) ? ELAPSED_MAX
                                                              : elapsed_base + MS_STEP;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < POINT_REGS; i++) begin
            point_ff[i] <= '0;
         end
         num_points_ff <= '0;
         loop_start_ff <= '0;
         loop_end_ff   <= '1;
         release_ms_ff <= '0;
         state_ff      <= S_IDLE;
         seg_idx_ff    <= '0;
         releasing_ff  <= 1'b0;
         elapsed_ff    <= '0;
         cur_level_ff  <= '0;
         rel_level_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         for (int i = 0; i < POINT_REGS; i++) begin
            point_ff[i] <= point_in[i];
         end
         num_points_ff <= num_points_in;
         loop_start_ff <= loop_start_in;
         loop_end_ff   <= loop_end_in;
         release_ms_ff <= release_ms_in;
         state_ff      <= state_in;
         seg_idx_ff    <= seg_idx_in;
         releasing_ff  <= releasing_in;
         elapsed_ff    <= elapsed_in;
         cur_level_ff  <= cur_level_in;
         rel_level_ff  <= rel_level_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff      <= left_in;
      right_ff     <= right_in;
      total_ff     <= total_in;
      to_ff        <= to_in;
      from_ff      <= from_in;
      dur_ff       <= dur_in;
      curved_ff    <= curved_in;
      adv_ff       <= adv_in;
      end_ff       <= end_in;
      pass_ff      <= pass_in;
      t_ff         <= t_in;
      lvl_ff       <= lvl_in;
      res_left_ff  <= res_left_in;
      res_right_ff <= res_right_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
      rsp_level_ff <= rsp_level_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.left_out  = rsp_left_ff;
   assign rsp_ch.right_out = rsp_right_ff;
   assign rsp_ch.level     = rsp_level_ff;

endmodule

FILE: rtl/core/mpeg_chk.sv
// ----------------------------------------------------------------------------
// mpeg_chk
// Port-level checks for the envelope generator, bound to the top level.
// ----------------------------------------------------------------------------
module mpeg_chk (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [mpeg_pkg::SAMPLE_W-1:0]   rsp_left_out,
   input logic [mpeg_pkg::SAMPLE_W-1:0]   rsp_right_out,
   input logic [mpeg_pkg::LEVEL_W-1:0]    rsp_level
);
   import mpeg_pkg::*;

   logic [1:0] open_ff, open_in;
   logic       req_xfer;
   logic       rsp_xfer;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   // requests taken but not yet answered
   always_comb begin
      open_in = open_ff;
      if (req_xfer && !rsp_xfer) begin
         open_in = open_ff + 1'b1;
      end else if (!req_xfer && rsp_xfer) begin
         open_in = open_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before transfer");

   a_no_orphan_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> open_ff != 2'd0)
      else $error("response without a pending request");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      req_xfer |-> open_ff <= 2'd1)
      else $error("more than two requests in flight");

   a_zero_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_level == '0 |-> rsp_left_out == '0 && rsp_right_out == '0)
      else $error("nonzero sample at zero level");

endmodule

bind multi_point_envelope_generator mpeg_chk u_mpeg_chk (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_left_out  (rsp_ch.left_out),
   .rsp_right_out (rsp_ch.right_out),
   .rsp_level     (rsp_ch.level)
);
